FILE: design/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, widths and codes of the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int DATA_W        = 16;
    localparam int PAIR_W        = 17;
    localparam int QUO_W         = 16;

    // axis codes, also the component order x y z w
    typedef logic [1:0] t_axis;
    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;
    localparam t_axis AXIS_W = 2'd3;

    // data that rides beside the square root pipeline
    typedef struct packed {
        t_axis                    big;
        logic                     bad;
        logic signed [PAIR_W-1:0] p0;
        logic signed [PAIR_W-1:0] p1;
        logic signed [PAIR_W-1:0] p2;
    } t_side;

    // width of a signed diagonal sum
    function automatic int e_width(input int fb);
        return ((fb + 2 > 18) ? fb + 2 : 18) + 1;
    endfunction

    // bits of the square root radicand (positive sum shifted by fb)
    function automatic int rad_width(input int fb);
        return e_width(fb) - 1 + fb;
    endfunction

    // bits of the integer square root
    function automatic int root_width(input int fb);
        return (rad_width(fb) + 1) / 2;
    endfunction

    // bits of the divisor, four times half the root
    function automatic int div_width(input int fb);
        return root_width(fb) + 1;
    endfunction

    // width of the divider remainder path
    function automatic int rem_width(input int fb);
        return ((PAIR_W + fb) > (div_width(fb) + QUO_W)) ?
               (PAIR_W + fb) : (div_width(fb) + QUO_W);
    endfunction

endpackage

`default_nettype wire

FILE: design/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_if
// Valid/ready channels for matrix input and quaternion output transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rmq_pkg::DATA_W-1:0]    m11, m12, m13;
    logic signed [rmq_pkg::DATA_W-1:0]    m21, m22, m23;
    logic signed [rmq_pkg::DATA_W-1:0]    m31, m32, m33;

    modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    input ready);
    modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    output ready);
endinterface

interface rmq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rmq_pkg::DATA_W-1:0]    quat_x, quat_y, quat_z, quat_w;
    rmq_pkg::t_axis                       major_axis;
    logic                                 bad_matrix;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, major_axis,
                    bad_matrix, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, major_axis,
                    bad_matrix, output ready);
endinterface

`default_nettype wire

FILE: design/rmq_sum.sv
// ----------------------------------------------------------------------------
// rmq_sum
// Diagonal sums, largest-sum pick and off-diagonal pair selection, one stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sum #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_vld,
    input  wire logic signed [rmq_pkg::DATA_W-1:0]   i_m11, i_m12, i_m13,
    input  wire logic signed [rmq_pkg::DATA_W-1:0]   i_m21, i_m22, i_m23,
    input  wire logic signed [rmq_pkg::DATA_W-1:0]   i_m31, i_m32, i_m33,
    output logic                                     o_vld,
    output logic [rmq_pkg::e_width(FRAC_BITS)-2:0]   o_e,
    output rmq_pkg::t_side                           o_side
);
    localparam int EW = rmq_pkg::e_width(FRAC_BITS);
    localparam int PW = rmq_pkg::PAIR_W;

    logic signed [EW-1:0] a11, a22, a33, one;
    logic signed [EW-1:0] e0, e1, e2, e3, e_big;
    logic signed [PW-1:0] sxy, sxz, syz, dx, dy, dz;
    rmq_pkg::t_axis       big;
    rmq_pkg::t_side       n_side;
    logic                 r_vld;
    logic [EW-2:0]        r_e;
    rmq_pkg::t_side       r_side;

    // diagonal sums
    always_comb begin
        a11 = EW'(i_m11);
        a22 = EW'(i_m22);
        a33 = EW'(i_m33);
        one = EW'(1) << FRAC_BITS;
        e0  = a11 - a22 - a33 + one;
        e1  = a22 - a11 - a33 + one;
        e2  = a33 - a11 - a22 + one;
        e3  = a11 + a22 + a33 + one;
    end

    // largest sum, lower index wins a tie
    always_comb begin
        big   = rmq_pkg::AXIS_X;
        e_big = e0;
        if (e1 > e_big) begin
            big   = rmq_pkg::AXIS_Y;
            e_big = e1;
        end
        if (e2 > e_big) begin
            big   = rmq_pkg::AXIS_Z;
            e_big = e2;
        end
        if (e3 > e_big) begin
            big   = rmq_pkg::AXIS_W;
            e_big = e3;
        end
    end

    // off-diagonal pairs
    always_comb begin
        sxy = PW'(i_m12) + PW'(i_m21);
        sxz = PW'(i_m31) + PW'(i_m13);
        syz = PW'(i_m23) + PW'(i_m32);
        dx  = PW'(i_m23) - PW'(i_m32);
        dy  = PW'(i_m31) - PW'(i_m13);
        dz  = PW'(i_m12) - PW'(i_m21);
    end

    // pairs of the three minor components, in x y z w order
    always_comb begin
        n_side.big = big;
        n_side.bad = (e_big <= 0);
        case (big)
            rmq_pkg::AXIS_X: begin
                n_side.p0 = sxy; n_side.p1 = sxz; n_side.p2 = dx;
            end
            rmq_pkg::AXIS_Y: begin
                n_side.p0 = sxy; n_side.p1 = syz; n_side.p2 = dy;
            end
            rmq_pkg::AXIS_Z: begin
                n_side.p0 = sxz; n_side.p1 = syz; n_side.p2 = dz;
            end
            default: begin
                n_side.p0 = dx;  n_side.p1 = dy;  n_side.p2 = dz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e    <= e_big[EW-2:0];
            r_side <= n_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_e    = r_e;
    assign o_side = r_side;
endmodule

`default_nettype wire

FILE: design/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_en,
    input  wire logic                                   i_vld,
    input  wire logic [rmq_pkg::rad_width(FRAC_BITS)-1:0] i_rad,
    output logic                                        o_vld,
    output logic [rmq_pkg::root_width(FRAC_BITS)-1:0]   o_root
);
    localparam int RADW = rmq_pkg::rad_width(FRAC_BITS);
    localparam int RW   = rmq_pkg::root_width(FRAC_BITS);

    logic              r_vld  [RW];
    logic [RW+1:0]     r_rem  [RW];
    logic [RW-1:0]     r_root [RW];
    logic [2*RW-1:0]   r_rad  [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic          vld_in;
            logic [RW+1:0] rem_in, rem_sh, trial;
            logic [RW-1:0] root_in;
            logic [2*RW-1:0] rad_in;
            logic          ge;

            // stage input
            if (k == 0) begin : g_first
                assign vld_in  = i_vld;
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = (2*RW)'(i_rad);
            end else begin : g_next
                assign vld_in  = r_vld[k-1];
                assign rem_in  = r_rem[k-1];
                assign root_in = r_root[k-1];
                assign rad_in  = r_rad[k-1];
            end

            // trial subtract of one root digit
            always_comb begin
                rem_sh = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
                trial  = {root_in, 2'b01};
                ge     = (rem_sh >= trial);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= ge ? (rem_sh - trial) : rem_sh;
                    r_root[k] <= {root_in[RW-2:0], ge};
                    r_rad[k]  <= {rad_in[2*RW-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
endmodule

`default_nettype wire

FILE: design/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined signed restoring divider with saturation for one minor component.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_en,
    input  wire logic                                    i_vld,
    input  wire logic signed [rmq_pkg::PAIR_W-1:0]       i_pair,
    input  wire logic [rmq_pkg::div_width(FRAC_BITS)-1:0] i_d,
    output logic                                         o_vld,
    output logic signed [rmq_pkg::DATA_W-1:0]            o_comp
);
    localparam int QW = rmq_pkg::QUO_W;
    localparam int DW = rmq_pkg::div_width(FRAC_BITS);
    localparam int WW = rmq_pkg::rem_width(FRAC_BITS);
    localparam int NS = QW + 1;

    logic              r_vld [NS];
    logic [WW-1:0]     r_rem [NS];
    logic [DW-1:0]     r_d   [NS];
    logic [QW-1:0]     r_q   [NS];
    logic              r_neg [NS];
    logic              r_ovf [NS];

    logic              neg_in;
    logic [rmq_pkg::PAIR_W-1:0] mag_in;
    logic [WW-1:0]     num_in;
    logic              big_q;

    // magnitude of the pair, scaled by the fraction bits
    always_comb begin
        neg_in = i_pair[rmq_pkg::PAIR_W-1];
        mag_in = neg_in ? rmq_pkg::PAIR_W'(-i_pair) : rmq_pkg::PAIR_W'(i_pair);
        num_in = WW'(mag_in) << FRAC_BITS;
    end

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            logic [WW-1:0] n_rem;
            logic [QW-1:0] n_q;
            logic          n_ovf;
            logic          vld_prev;
            logic [DW-1:0] d_prev;
            logic          neg_prev;

            if (s == 0) begin : g_first
                assign vld_prev = i_vld;
                assign d_prev   = i_d;
                assign neg_prev = neg_in;

                // quotient beyond the kept bits saturates
                always_comb begin
                    n_rem = num_in;
                    n_q   = '0;
                    n_ovf = (num_in >= (WW'(i_d) << QW));
                end
            end else begin : g_next
                logic [WW-1:0] sub;
                logic          ge;

                assign vld_prev = r_vld[s-1];
                assign d_prev   = r_d[s-1];
                assign neg_prev = r_neg[s-1];

                always_comb begin
                    sub   = WW'(r_d[s-1]) << (QW - s);
                    ge    = (r_rem[s-1] >= sub);
                    n_rem = ge ? (r_rem[s-1] - sub) : r_rem[s-1];
                    n_q   = r_q[s-1];
                    n_q[QW-s] = ge;
                    n_ovf = r_ovf[s-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= vld_prev;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_q[s]   <= n_q;
                    r_ovf[s] <= n_ovf;
                    r_d[s]   <= d_prev;
                    r_neg[s] <= neg_prev;
                end
            end
        end
    endgenerate

    // signed saturation of the quotient
    always_comb begin
        big_q = r_ovf[NS-1] | r_q[NS-1][QW-1];
        if (r_neg[NS-1]) begin
            o_comp = big_q ? {1'b1, {(rmq_pkg::DATA_W-1){1'b0}}}
                           : rmq_pkg::DATA_W'(-r_q[NS-1]);
        end else begin
            o_comp = big_q ? {1'b0, {(rmq_pkg::DATA_W-1){1'b1}}}
                           : rmq_pkg::DATA_W'(r_q[NS-1]);
        end
    end

    assign o_vld = r_vld[NS-1];
endmodule

`default_nettype wire

FILE: design/rotation_matrix_to_quaternion_core.sv
// Pipeline: one sum stage, one square root stage per root bit,
//   17 divider stages, output.
// Throughput: one transaction per cycle; the whole pipeline holds on output stall.
// Reset: synchronous active-low reset clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Shepperd conversion of a fixed-point rotation matrix to a unit quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rmq_in_if.sink      i_mat,
    rmq_out_if.source   o_quat
);
    localparam int EW = rmq_pkg::e_width(FRAC_BITS);
    localparam int RW = rmq_pkg::root_width(FRAC_BITS);
    localparam int DW = rmq_pkg::div_width(FRAC_BITS);
    localparam int NS = rmq_pkg::QUO_W + 1;
    localparam int QD = rmq_pkg::DATA_W;

    logic                  en;
    logic                  sum_vld, sq_vld;
    logic [EW-2:0]         sum_e;
    rmq_pkg::t_side        sum_side;
    logic [RW-1:0]         sq_root;
    logic [DW-1:0]         d;
    logic [RW-2:0]         v;
    logic signed [QD-1:0]  v_sat;
    logic                  dv_vld [3];
    logic signed [QD-1:0]  dv_comp [3];

    rmq_pkg::t_side        r_side [RW];
    rmq_pkg::t_axis        r_big  [NS];
    logic                  r_bad  [NS];
    logic signed [QD-1:0]  r_vmaj [NS];

    logic                  r_ovld;
    logic signed [QD-1:0]  r_qx, r_qy, r_qz, r_qw;
    rmq_pkg::t_axis        r_axis;
    logic                  r_bad_o;
    logic signed [QD-1:0]  n_qx, n_qy, n_qz, n_qw;

    // pipeline advances unless a held result is not taken
    assign en          = !r_ovld || o_quat.ready;
    assign i_mat.ready = en;

    rmq_sum #(.FRAC_BITS(FRAC_BITS)) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_mat.valid),
        .i_m11   (i_mat.m11), .i_m12 (i_mat.m12), .i_m13 (i_mat.m13),
        .i_m21   (i_mat.m21), .i_m22 (i_mat.m22), .i_m23 (i_mat.m23),
        .i_m31   (i_mat.m31), .i_m32 (i_mat.m32), .i_m33 (i_mat.m33),
        .o_vld   (sum_vld),
        .o_e     (sum_e),
        .o_side  (sum_side)
    );

    rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sum_vld),
        .i_rad   ({sum_e, {FRAC_BITS{1'b0}}}),
        .o_vld   (sq_vld),
        .o_root  (sq_root)
    );

    // sideband beside the square root
    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_side
            rmq_pkg::t_side side_prev;

            if (k == 0) begin : g_first
                assign side_prev = sum_side;
            end else begin : g_next
                assign side_prev = r_side[k-1];
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_side[k] <= side_prev;
                end
            end
        end
    endgenerate

    // half root is the major component, four times it the divisor
    always_comb begin
        v     = sq_root[RW-1:1];
        d     = {v, 2'b00};
        v_sat = (v > (RW-1)'(32767)) ? QD'(32767) : QD'(v);
    end

    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_vld (sq_vld),
        .i_pair (r_side[RW-1].p0), .i_d (d),
        .o_vld (dv_vld[0]), .o_comp (dv_comp[0])
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_vld (sq_vld),
        .i_pair (r_side[RW-1].p1), .i_d (d),
        .o_vld (dv_vld[1]), .o_comp (dv_comp[1])
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_vld (sq_vld),
        .i_pair (r_side[RW-1].p2), .i_d (d),
        .o_vld (dv_vld[2]), .o_comp (dv_comp[2])
    );

    // axis, error flag and major component beside the dividers
    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_tail
            rmq_pkg::t_axis       big_prev;
            logic                 bad_prev;
            logic signed [QD-1:0] vmaj_prev;

            if (s == 0) begin : g_first
                assign big_prev  = r_side[RW-1].big;
                assign bad_prev  = r_side[RW-1].bad;
                assign vmaj_prev = v_sat;
            end else begin : g_next
                assign big_prev  = r_big[s-1];
                assign bad_prev  = r_bad[s-1];
                assign vmaj_prev = r_vmaj[s-1];
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_big[s]  <= big_prev;
                    r_bad[s]  <= bad_prev;
                    r_vmaj[s] <= vmaj_prev;
                end
            end
        end
    endgenerate

    // place components by major axis, all zero for a bad matrix
    always_comb begin
        case (r_big[NS-1])
            rmq_pkg::AXIS_X: begin
                n_qx = r_vmaj[NS-1]; n_qy = dv_comp[0];
                n_qz = dv_comp[1];   n_qw = dv_comp[2];
            end
            rmq_pkg::AXIS_Y: begin
                n_qx = dv_comp[0];   n_qy = r_vmaj[NS-1];
                n_qz = dv_comp[1];   n_qw = dv_comp[2];
            end
            rmq_pkg::AXIS_Z: begin
                n_qx = dv_comp[0];   n_qy = dv_comp[1];
                n_qz = r_vmaj[NS-1]; n_qw = dv_comp[2];
            end
            default: begin
                n_qx = dv_comp[0];   n_qy = dv_comp[1];
                n_qz = dv_comp[2];   n_qw = r_vmaj[NS-1];
            end
        endcase
        if (r_bad[NS-1]) begin
            n_qx = '0; n_qy = '0; n_qz = '0; n_qw = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= dv_vld[0] & dv_vld[1] & dv_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qx    <= n_qx;
            r_qy    <= n_qy;
            r_qz    <= n_qz;
            r_qw    <= n_qw;
            r_axis  <= r_big[NS-1];
            r_bad_o <= r_bad[NS-1];
        end
    end

    assign o_quat.valid      = r_ovld;
    assign o_quat.quat_x     = r_qx;
    assign o_quat.quat_y     = r_qy;
    assign o_quat.quat_z     = r_qz;
    assign o_quat.quat_w     = r_qw;
    assign o_quat.major_axis = r_axis;
    assign o_quat.bad_matrix = r_bad_o;
endmodule

`default_nettype wire
